// ===== rtl/core/smae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_pkg: shared types and constants
// Command, operation and status codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package smae_pkg;

  localparam int unsigned MAX_DIM_DEF    = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_READ = 2'd2,
    CMD_RUN  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_SCALE = 3'd3,
    OP_TRANS = 3'd4,
    OP_DET   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DIM   = 2'd2,
    ST_DET   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_OPERATION  = 3'd0,
    CFG_LEFT_ROWS  = 3'd1,
    CFG_LEFT_COLS  = 3'd2,
    CFG_RIGHT_ROWS = 3'd3,
    CFG_RIGHT_COLS = 3'd4,
    CFG_SCALE      = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a word
    S_CLEAR,  // sweep both stores to zero after reset
    S_ELEM,   // element read data arrives
    S_RD,     // issue operand reads for next step
    S_MUL,    // operands registered, multiply
    S_ACC,    // product registered, fold into accumulator
    S_EMIT,   // hold a result word until taken
    S_WB      // element write-back
  } state_t;

endpackage

// ===== rtl/core/smae_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_in_if / smae_out_if: valid/ready channels
// Input command word and result word channels.
// ----------------------------------------------------------------------------
interface smae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        matrix_sel;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic signed [31:0] data_value;
  modport source (output valid, cmd, matrix_sel, row_index, col_index, data_value,
                  input ready);
  modport sink   (input valid, cmd, matrix_sel, row_index, col_index, data_value,
                  output ready);
endinterface

interface smae_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [2:0]  result_row;
  logic [2:0]  result_col;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, result_value, result_row, result_col, status, last,
                  input ready);
  modport sink   (input valid, result_value, result_row, result_col, status, last,
                  output ready);
endinterface

// ===== rtl/core/smae_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module smae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/small_matrix_arithmetic_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_engine_top: Q-format matrix engine
// Two element stores, one shared multiplier and accumulator under a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in      | in  | valid/ready   | cmd, matrix_sel, row_index, col_index, data_value
//  out     | out | valid/ready   | result_value, result_row, result_col, status, last
//  cfg     | in  | we            | cfg_index, cfg_data
//
//  After reset a clearing pass over all MAX_DIM*MAX_DIM addresses zeroes both
//  stores; no word is taken meanwhile. An element word passes S_ELEM, then S_WB
//  when it writes a store, then S_EMIT for the result handshake. A run passes
//  read, multiply and accumulate for each multiply-accumulate step and emits
//  each result word in turn; the single shared multiplier serialises the steps.
//  in_ready is high only in idle; out stalls hold the sequencer in place.
module small_matrix_arithmetic_engine_top #(
  parameter int unsigned MAX_DIM    = smae_pkg::MAX_DIM_DEF,
  parameter int unsigned DATA_WIDTH = smae_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = smae_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  smae_in_if.sink    in_ch,
  smae_out_if.source out_ch,
  input  logic                            cfg_we,
  input  logic [smae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smae_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned XW     = (DW > 32) ? DW : 32;
  localparam int unsigned PW     = DW + XW;
  localparam int unsigned DLIM   = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int unsigned IW     = $clog2(MAX_DIM);
  localparam int unsigned ACCW   = XW + 8;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  // saturate a wide signed value to DW bits
  function automatic logic signed [DW-1:0] sat_acc(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = ACCW'(DMAX);
    lo = ACCW'(DMIN);
    if (v > hi) return DMAX;
    else if (v < lo) return DMIN;
    else return v[DW-1:0];
  endfunction

  // saturate a DW-bit value to the 32-bit result field
  function automatic logic signed [31:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [ACCW-1:0] w;
    w = ACCW'(v);
    if (w > ACCW'(32'sh7fffffff)) return 32'sh7fffffff;
    else if (w < ACCW'(32'sh80000000)) return 32'sh80000000;
    else return w[31:0];
  endfunction

  // clamp a dimension register to 1..DLIM
  function automatic logic [3:0] eff_dim(input logic [3:0] r);
    if (r == 4'd0) return 4'd1;
    else if (r > 4'(DLIM)) return 4'(DLIM);
    else return r;
  endfunction

  // ---- configuration registers
  logic [2:0]  op_r;
  logic [3:0]  lrows_r, lcols_r, rrows_r, rcols_r;
  logic signed [31:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= 3'd0;
      lrows_r <= 4'd8;
      lcols_r <= 4'd8;
      rrows_r <= 4'd8;
      rcols_r <= 4'd8;
      scale_r <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smae_pkg::CFG_OPERATION:  op_r    <= cfg_data[2:0];
        smae_pkg::CFG_LEFT_ROWS:  lrows_r <= cfg_data[3:0];
        smae_pkg::CFG_LEFT_COLS:  lcols_r <= cfg_data[3:0];
        smae_pkg::CFG_RIGHT_ROWS: rrows_r <= cfg_data[3:0];
        smae_pkg::CFG_RIGHT_COLS: rcols_r <= cfg_data[3:0];
        smae_pkg::CFG_SCALE:      scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] lr, lc, rr, rc;
  assign lr = eff_dim(lrows_r);
  assign lc = eff_dim(lcols_r);
  assign rr = eff_dim(rrows_r);
  assign rc = eff_dim(rcols_r);

  // input data brought to DW bits, saturated where DW < 32
  logic signed [DW-1:0] din_dw;
  always_comb begin
    din_dw = sat_acc(ACCW'(in_ch.data_value));
  end

  // ---- sequencer registers
  smae_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic [1:0]    cmd_r;
  logic          sel_r;
  logic [2:0]    row_r, col_r;
  logic signed [DW-1:0] din_r;
  logic [3:0]    r_r, c_r, k_r;   // run loop counters
  logic          ph_r;            // determinant: second product phase
  logic signed [ACCW-1:0] acc_r;
  logic signed [PW-1:0]   prod_r;

  // ---- result word register
  logic signed [DW-1:0] o_val_r;
  logic [2:0]  o_row_r, o_col_r;
  logic [1:0]  o_st_r;
  logic        o_last_r;

  // ---- stores
  logic          l_we, r_we;
  logic [AW-1:0] l_addr, r_addr;
  logic [DW-1:0] l_wd, r_wd, l_rd, r_rd;

  smae_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_left (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
  smae_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_right (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd));

  function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [3:0] c);
    return AW'(r[IW-1:0]) * AW'(MAX_DIM) + AW'(c[IW-1:0]);
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // product >> FRAC_BITS (floor), folded into accumulator width with saturation
  logic signed [PW-1:0]   shp;
  logic signed [ACCW-1:0] shp_w;
  logic signed [DW-1:0]   shp_sat;
  always_comb begin
    shp = prod_r >>> FRAC_BITS;
    if (shp > PW'(DMAX)) shp_sat = DMAX;
    else if (shp < PW'(DMIN)) shp_sat = DMIN;
    else shp_sat = shp[DW-1:0];
    shp_w = ACCW'(shp_sat);
  end

  logic [3:0] run_rows, run_cols;
  always_comb begin
    run_rows = lr;
    run_cols = lc;
    if (op_r == smae_pkg::OP_MUL) run_cols = rc;
    else if (op_r == smae_pkg::OP_TRANS) begin
      run_rows = lc;
      run_cols = lr;
    end
  end

  // element range check on the word in flight
  logic elem_oor;
  assign elem_oor = sel_r ? ({1'b0, row_r} >= rr || {1'b0, col_r} >= rc)
                          : ({1'b0, row_r} >= lr || {1'b0, col_r} >= lc);

  logic signed [DW-1:0] elem_rd;
  logic signed [ACCW-1:0] elem_sum;
  assign elem_rd  = sel_r ? r_rd : l_rd;
  assign elem_sum = ACCW'(elem_rd) + ACCW'(din_r);

  // operation path
  logic is_mac_op;
  assign is_mac_op = (op_r == smae_pkg::OP_MUL) || (op_r == smae_pkg::OP_DET);
  logic last_elem;
  assign last_elem = (r_r == run_rows - 4'd1) && (c_r == run_cols - 4'd1);

  // ---- next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smae_pkg::S_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = smae_pkg::S_IDLE;
      smae_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd != smae_pkg::CMD_RUN) state_nxt = smae_pkg::S_ELEM;
          else begin
            priority if (op_r == smae_pkg::OP_MUL && lc != rr) state_nxt = smae_pkg::S_EMIT;
            else if ((op_r == smae_pkg::OP_ADD || op_r == smae_pkg::OP_SUB)
                     && (lr != rr || lc != rc)) state_nxt = smae_pkg::S_EMIT;
            else if (op_r == smae_pkg::OP_DET && (lr != 4'd2 || lc != 4'd2))
              state_nxt = smae_pkg::S_EMIT;
            else if (op_r > smae_pkg::OP_DET) state_nxt = smae_pkg::S_IDLE;
            else state_nxt = smae_pkg::S_RD;
          end
        end
      end
      smae_pkg::S_ELEM: state_nxt = (!elem_oor && cmd_r != smae_pkg::CMD_READ)
                                    ? smae_pkg::S_WB : smae_pkg::S_EMIT;
      smae_pkg::S_WB:   state_nxt = smae_pkg::S_EMIT;
      smae_pkg::S_RD:   state_nxt = smae_pkg::S_MUL;
      smae_pkg::S_MUL: begin
        if (is_mac_op || op_r == smae_pkg::OP_SCALE) state_nxt = smae_pkg::S_ACC;
        else state_nxt = smae_pkg::S_EMIT;
      end
      smae_pkg::S_ACC: begin
        priority if (op_r == smae_pkg::OP_MUL && k_r != lc - 4'd1) state_nxt = smae_pkg::S_RD;
        else if (op_r == smae_pkg::OP_DET && !ph_r) state_nxt = smae_pkg::S_RD;
        else state_nxt = smae_pkg::S_EMIT;
      end
      smae_pkg::S_EMIT: begin
        if (out_fire) state_nxt = o_last_r ? smae_pkg::S_IDLE : smae_pkg::S_RD;
      end
      default: state_nxt = smae_pkg::S_IDLE;
    endcase
  end

  // ---- store address and write control
  always_comb begin
    l_we = 1'b0; r_we = 1'b0;
    l_addr = '0; r_addr = '0;
    l_wd = '0;  r_wd = '0;
    unique case (state_r)
      smae_pkg::S_CLEAR: begin
        l_we = 1'b1; r_we = 1'b1;
        l_addr = clr_r; r_addr = clr_r;
      end
      smae_pkg::S_IDLE: begin
        l_addr = addr_of({1'b0, in_ch.row_index}, {1'b0, in_ch.col_index});
        r_addr = l_addr;
      end
      smae_pkg::S_WB: begin
        l_addr = addr_of({1'b0, row_r}, {1'b0, col_r});
        r_addr = l_addr;
        l_we = !sel_r; r_we = sel_r;
        l_wd = o_val_r; r_wd = l_wd;
      end
      smae_pkg::S_RD: begin
        priority case (1'b1)
          op_r == smae_pkg::OP_MUL: begin
            l_addr = addr_of(r_r, k_r);
            r_addr = addr_of(k_r, c_r);
          end
          op_r == smae_pkg::OP_TRANS: l_addr = addr_of(c_r, r_r);
          op_r == smae_pkg::OP_DET: begin
            l_addr = ph_r ? addr_of(4'd0, 4'd1) : addr_of(4'd0, 4'd0);
            r_addr = '0;
          end
          default: begin
            l_addr = addr_of(r_r, c_r);
            r_addr = l_addr;
          end
        endcase
      end
      default: ;
    endcase
  end

  // determinant: the first operand of each product comes from the left store
  // (L00, then L01); the second is taken from the row-1 shadow below
  logic signed [DW-1:0] det_b;

  // ---- datapath registers
  logic signed [ACCW-1:0] acc_sum;
  assign acc_sum = (ph_r && op_r == smae_pkg::OP_DET) ? acc_r - shp_w : acc_r + shp_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= smae_pkg::S_CLEAR;
      clr_r    <= '0;
      o_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == smae_pkg::S_CLEAR) clr_r <= clr_r + AW'(1);
      unique case (state_r)
        smae_pkg::S_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_ch.cmd;
            sel_r <= in_ch.matrix_sel;
            row_r <= in_ch.row_index;
            col_r <= in_ch.col_index;
            din_r <= din_dw;
            r_r <= '0; c_r <= '0; k_r <= '0; ph_r <= 1'b0;
            acc_r <= '0;
            o_val_r <= '0; o_row_r <= '0; o_col_r <= '0;
            o_last_r <= 1'b1;
            if (in_ch.cmd == smae_pkg::CMD_RUN) begin
              o_st_r <= (op_r == smae_pkg::OP_DET) ? smae_pkg::ST_DET : smae_pkg::ST_DIM;
            end
          end
        end
        smae_pkg::S_ELEM: begin
          o_row_r  <= row_r;
          o_col_r  <= col_r;
          o_last_r <= 1'b1;
          if (elem_oor) begin
            o_st_r  <= smae_pkg::ST_RANGE;
            o_val_r <= '0;
          end else begin
            o_st_r <= smae_pkg::ST_OK;
            unique case (cmd_r)
              smae_pkg::CMD_SET: o_val_r <= din_r;
              smae_pkg::CMD_ADD: o_val_r <= sat_acc(elem_sum);
              default:           o_val_r <= elem_rd;
            endcase
          end
        end
        smae_pkg::S_MUL: begin
          // l_rd / r_rd hold this step's operands
          priority case (1'b1)
            op_r == smae_pkg::OP_MUL:
              prod_r <= PW'($signed(l_rd)) * PW'($signed(r_rd));
            op_r == smae_pkg::OP_SCALE:
              prod_r <= PW'($signed(l_rd)) * PW'(scale_r);
            op_r == smae_pkg::OP_DET:
              prod_r <= PW'($signed(l_rd)) * PW'(det_b);
            default: ;
          endcase
          if (op_r == smae_pkg::OP_ADD || op_r == smae_pkg::OP_SUB
              || op_r == smae_pkg::OP_TRANS) begin
            o_st_r <= smae_pkg::ST_OK;
            o_row_r <= r_r[2:0];
            o_col_r <= c_r[2:0];
            o_last_r <= last_elem;
            priority case (1'b1)
              op_r == smae_pkg::OP_ADD:
                o_val_r <= sat_acc(ACCW'($signed(l_rd)) + ACCW'($signed(r_rd)));
              op_r == smae_pkg::OP_SUB:
                o_val_r <= sat_acc(ACCW'($signed(l_rd)) - ACCW'($signed(r_rd)));
              default: o_val_r <= $signed(l_rd);
            endcase
          end
        end
        smae_pkg::S_ACC: begin
          o_st_r   <= smae_pkg::ST_OK;
          o_row_r  <= r_r[2:0];
          o_col_r  <= c_r[2:0];
          if (op_r == smae_pkg::OP_SCALE) begin
            o_val_r  <= shp_sat;
            o_last_r <= last_elem;
          end else begin
            acc_r <= acc_sum;
            o_val_r  <= sat_acc(acc_sum);
            if (op_r == smae_pkg::OP_DET) begin
              ph_r <= 1'b1;
              o_last_r <= 1'b1;
            end else begin
              k_r <= k_r + 4'd1;
              o_last_r <= last_elem;
            end
          end
        end
        smae_pkg::S_EMIT: begin
          if (out_fire) begin
            acc_r <= '0;
            k_r   <= '0;
            if (c_r == run_cols - 4'd1) begin
              c_r <= '0;
              r_r <= r_r + 4'd1;
            end else begin
              c_r <= c_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // shadow of L10 and L11, kept in step with every left-store write so the
  // determinant gets its second operand without a second read port
  logic signed [DW-1:0] l10_r, l11_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l10_r <= '0;
      l11_r <= '0;
    end else if (l_we && l_addr == addr_of(4'd1, 4'd0)) l10_r <= l_wd;
    else if (l_we && l_addr == addr_of(4'd1, 4'd1)) l11_r <= l_wd;
  end
  // L11 pairs with L00, then L10 pairs with L01
  always_comb det_b = ph_r ? l10_r : l11_r;

  // ---- ports
  assign in_ch.ready = (state_r == smae_pkg::S_IDLE);
  assign out_ch.valid        = (state_r == smae_pkg::S_EMIT);
  assign out_ch.result_value = sat_out(o_val_r);
  assign out_ch.result_row   = o_row_r;
  assign out_ch.result_col   = o_col_r;
  assign out_ch.status       = o_st_r;
  assign out_ch.last         = o_last_r;

  // ---- checks
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != smae_pkg::S_IDLE |-> !in_ch.ready)
    else $error("input taken while busy");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(o_val_r))
    else $error("result dropped under stall");
  a_clear_first: assert property (@(posedge clk)
    $past(!rst_n) && !rst_n |=> state_r == smae_pkg::S_CLEAR)
    else $error("clearing pass skipped");
  a_det_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r && state_r == smae_pkg::S_ACC |-> op_r == smae_pkg::OP_DET)
    else $error("phase set outside determinant");
endmodule
